@@ rtl/ihp_pkg.sv @@
package ihp_pkg;

	// Table depth; the resource field stays 4 bits wide regardless.
	localparam int NUM_RESOURCES = 16;
	localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RESOURCES - 1);
	// Wide enough to compare a 4-bit resource against a table depth of up to 255.
	localparam int CMP_W = 8;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_ACCESS = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	localparam logic [1:0] KIND_PASS  = 2'd0;
	localparam logic [1:0] KIND_TRAIL = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [2:0] LAYOUT_UNDEFINED = 3'd0;
	localparam logic [5:0] STAGE_NONE       = 6'd0;
	localparam logic [8:0] ACCESS_NONE      = 9'd0;

	// Controller to datapath.
	typedef struct packed {
		logic             in_load;
		logic             exec;
		logic             walk_step;
		logic             emit_done;
		logic [IDX_W-1:0] walk_idx;
	} ihp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic op_finish;
		logic out_valid;
	} ihp_sts_t;

	function automatic logic [2:0] layout_of_usage(input logic [2:0] usage);
		logic [2:0] lay;
		case (usage)
			3'd0:    lay = 3'd1;
			3'd1:    lay = 3'd2;
			3'd2:    lay = 3'd3;
			3'd3:    lay = 3'd4;
			3'd4:    lay = 3'd4;
			3'd5:    lay = 3'd5;
			3'd6:    lay = 3'd6;
			default: lay = 3'd7;
		endcase
		return lay;
	endfunction

	function automatic logic [5:0] stage_of_usage(input logic [2:0] usage);
		logic [5:0] stg;
		case (usage)
			3'd0:    stg = 6'h01;
			3'd1:    stg = 6'h06;
			3'd2:    stg = 6'h08;
			3'd3:    stg = 6'h10;
			3'd4:    stg = 6'h10;
			3'd5:    stg = 6'h20;
			3'd6:    stg = 6'h20;
			default: stg = STAGE_NONE;
		endcase
		return stg;
	endfunction

	function automatic logic [8:0] access_of_usage(input logic [2:0] usage);
		logic [8:0] acc;
		case (usage)
			3'd0:    acc = 9'h003;
			3'd1:    acc = 9'h00C;
			3'd2:    acc = 9'h010;
			3'd3:    acc = 9'h020;
			3'd4:    acc = 9'h040;
			3'd5:    acc = 9'h080;
			3'd6:    acc = 9'h100;
			default: acc = ACCESS_NONE;
		endcase
		return acc;
	endfunction

endpackage

@@ rtl/image_barrier_hazard_planner.sv @@
// Image barrier hazard planner: per-resource layout and sync tracking.
// Input channel (in_valid/in_stall): one transaction per command. init loads a
// resource's start layout, final layout and imported flag; access checks the
// resource's layout and write history and may emit one pass barrier; finish
// walks all resources in index order, emits a trailing barrier for each
// imported resource that must still move to its final layout, then a done
// marker (last=1).
// Output channel (out_valid/out_stall): one transaction per barrier or marker.
// A transaction accepted into the held-command register executes once the
// output is free; its result is on the outputs from then on. The held-command
// register lets init and access run at one transaction per cycle while the
// output is free. finish first enters the walk, then takes NUM_RESOURCES walk
// steps and then emits the done marker; each of these needs a free output register.
// Out-of-range resources and op 3 are consumed with no result.
// Stall: a stalled result holds; the block keeps one command in its holding
// register and raises in_stall until that command can execute.
// Reset: the whole resource table clears at once (undefined layouts, no
// masks, not imported); no outputs are valid.
module image_barrier_hazard_planner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [3:0] resource,
	input  logic [2:0] usage,
	input  logic       writes,
	input  logic [2:0] start_layout,
	input  logic [2:0] end_layout,
	input  logic       external,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [3:0] res_index,
	output logic [2:0] from_layout,
	output logic [2:0] to_layout,
	output logic [5:0] src_stages,
	output logic [8:0] src_accesses,
	output logic [5:0] dst_stages,
	output logic [8:0] dst_accesses,
	output logic       last
);
	import ihp_pkg::*;

	ihp_cmd_t cmd;
	ihp_sts_t sts;

	// sequencer: holding-register occupancy, finish walk
	ihp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, barrier decision, result register
	ihp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.resource    (resource),
		.usage       (usage),
		.writes      (writes),
		.start_layout(start_layout),
		.end_layout  (end_layout),
		.external    (external),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.res_index   (res_index),
		.from_layout (from_layout),
		.to_layout   (to_layout),
		.src_stages  (src_stages),
		.src_accesses(src_accesses),
		.dst_stages  (dst_stages),
		.dst_accesses(dst_accesses),
		.last        (last)
	);

	// walker and command execution never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.walk_step && (cmd.exec || cmd.emit_done)))
		else $error("walk step overlaps command execution");

	// trailing barriers are never last and carry no destination masks
	a_trail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_TRAIL) |->
		(!last && dst_stages == STAGE_NONE && dst_accesses == ACCESS_NONE))
		else $error("malformed trailing barrier");

	// pass barriers and done markers close their command
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_PASS || kind == KIND_DONE)) |-> last)
		else $error("pass barrier or done marker without last");

	// a new result is only loaded when the previous one has gone
	a_noover: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(res_index)))
		else $error("stalled result overwritten");

endmodule

@@ rtl/ihp_ctrl.sv @@
module ihp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	input  ihp_pkg::ihp_sts_t sts,
	output ihp_pkg::ihp_cmd_t cmd
);
	import ihp_pkg::*;

	typedef enum logic [1:0] {
		S_RUN,
		S_WALK,
		S_MARK
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] walk_idx_q;
	logic             in_full_q;
	logic             out_free;
	logic             consume;

	always_comb begin
		out_free      = !sts.out_valid || !out_stall;
		cmd.exec      = (state_q == S_RUN) && in_full_q && out_free && !sts.op_finish;
		cmd.walk_step = (state_q == S_WALK) && out_free;
		cmd.emit_done = (state_q == S_MARK) && out_free;
		cmd.walk_idx  = walk_idx_q;
		consume       = cmd.exec || cmd.emit_done;
		in_stall      = in_full_q && !consume;
		cmd.in_load   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RUN;
			walk_idx_q <= '0;
			in_full_q  <= 1'b0;
		end else begin
			if (cmd.in_load) begin
				in_full_q <= 1'b1;
			end else if (consume) begin
				in_full_q <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					if (in_full_q && out_free && sts.op_finish) begin
						state_q    <= S_WALK;
						walk_idx_q <= '0;
					end
				end
				S_WALK: begin
					if (out_free) begin
						if (walk_idx_q == LAST_IDX) begin
							state_q <= S_MARK;
						end else begin
							walk_idx_q <= walk_idx_q + 1'b1;
						end
					end
				end
				S_MARK: begin
					if (out_free) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule

@@ rtl/ihp_dp.sv @@
module ihp_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ihp_pkg::ihp_cmd_t cmd,
	output ihp_pkg::ihp_sts_t sts,
	input  logic [1:0]        op,
	input  logic [3:0]        resource,
	input  logic [2:0]        usage,
	input  logic              writes,
	input  logic [2:0]        start_layout,
	input  logic [2:0]        end_layout,
	input  logic              external,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [1:0]        kind,
	output logic [3:0]        res_index,
	output logic [2:0]        from_layout,
	output logic [2:0]        to_layout,
	output logic [5:0]        src_stages,
	output logic [8:0]        src_accesses,
	output logic [5:0]        dst_stages,
	output logic [8:0]        dst_accesses,
	output logic              last
);
	import ihp_pkg::*;

	// held input transaction
	logic [1:0] op_q;
	logic [3:0] res_q;
	logic [2:0] usage_q;
	logic       wr_q;
	logic [2:0] start_q;
	logic [2:0] end_q;
	logic       ext_q;

	// per-resource state table
	logic [2:0] cur_q   [NUM_RESOURCES];
	logic [5:0] stage_q [NUM_RESOURCES];
	logic [8:0] acc_q   [NUM_RESOURCES];
	logic       wrote_q [NUM_RESOURCES];
	logic [2:0] fin_q   [NUM_RESOURCES];
	logic       imp_q   [NUM_RESOURCES];

	logic             out_valid_q;
	logic [IDX_W-1:0] rd_idx;
	logic             in_range;
	logic [2:0]       e_cur, e_fin, lay;
	logic [5:0]       e_stg, stg;
	logic [8:0]       e_acc, acc;
	logic             e_wrote, e_imp;
	logic             do_init, do_access, barrier, trail;

	always_comb begin
		rd_idx    = cmd.walk_step ? cmd.walk_idx : IDX_W'(res_q);
		in_range  = CMP_W'(res_q) < CMP_W'(NUM_RESOURCES);
		e_cur     = cur_q[rd_idx];
		e_stg     = stage_q[rd_idx];
		e_acc     = acc_q[rd_idx];
		e_wrote   = wrote_q[rd_idx];
		e_fin     = fin_q[rd_idx];
		e_imp     = imp_q[rd_idx];
		lay       = layout_of_usage(usage_q);
		stg       = stage_of_usage(usage_q);
		acc       = access_of_usage(usage_q);
		do_init   = cmd.exec && in_range && (op_q == OP_INIT);
		do_access = cmd.exec && in_range && (op_q == OP_ACCESS);
		barrier   = (e_cur != lay) || e_wrote || wr_q;
		trail     = e_imp && (e_fin != LAYOUT_UNDEFINED) && (e_fin != e_cur);
		sts.op_finish = (op_q == OP_FINISH);
		sts.out_valid = out_valid_q;
		out_valid     = out_valid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q    <= op;
			res_q   <= resource;
			usage_q <= usage;
			wr_q    <= writes;
			start_q <= start_layout;
			end_q   <= end_layout;
			ext_q   <= external;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				cur_q[i]   <= LAYOUT_UNDEFINED;
				stage_q[i] <= STAGE_NONE;
				acc_q[i]   <= ACCESS_NONE;
				wrote_q[i] <= 1'b0;
				fin_q[i]   <= LAYOUT_UNDEFINED;
				imp_q[i]   <= 1'b0;
			end
		end else begin
			if (do_init) begin
				cur_q[rd_idx]   <= start_q;
				fin_q[rd_idx]   <= end_q;
				imp_q[rd_idx]   <= ext_q;
				stage_q[rd_idx] <= STAGE_NONE;
				acc_q[rd_idx]   <= ACCESS_NONE;
				wrote_q[rd_idx] <= 1'b0;
			end else if (do_access) begin
				if (barrier) begin
					cur_q[rd_idx]   <= lay;
					stage_q[rd_idx] <= stg;
					acc_q[rd_idx]   <= acc;
					wrote_q[rd_idx] <= wr_q;
				end else begin
					stage_q[rd_idx] <= e_stg | stg;
					acc_q[rd_idx]   <= e_acc | acc;
				end
			end else if (cmd.walk_step && trail) begin
				cur_q[rd_idx] <= e_fin;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((do_access && barrier) || (cmd.walk_step && trail) || cmd.emit_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_access && barrier) begin
			kind         <= KIND_PASS;
			res_index    <= res_q;
			from_layout  <= e_cur;
			to_layout    <= lay;
			src_stages   <= e_stg;
			src_accesses <= e_acc;
			dst_stages   <= stg;
			dst_accesses <= acc;
			last         <= 1'b1;
		end else if (cmd.walk_step && trail) begin
			kind         <= KIND_TRAIL;
			res_index    <= 4'(cmd.walk_idx);
			from_layout  <= e_cur;
			to_layout    <= e_fin;
			src_stages   <= e_stg;
			src_accesses <= e_acc;
			dst_stages   <= STAGE_NONE;
			dst_accesses <= ACCESS_NONE;
			last         <= 1'b0;
		end else if (cmd.emit_done) begin
			kind         <= KIND_DONE;
			res_index    <= '0;
			from_layout  <= LAYOUT_UNDEFINED;
			to_layout    <= LAYOUT_UNDEFINED;
			src_stages   <= STAGE_NONE;
			src_accesses <= ACCESS_NONE;
			dst_stages   <= STAGE_NONE;
			dst_accesses <= ACCESS_NONE;
			last         <= 1'b1;
		end
	end

endmodule
